FILE: hdl/cle_pkg.sv
// shared types, constants and keystroke codes for the cursor line editor
package cle_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int CHW      = 8;

    typedef logic [AW-1:0]  addr_t;
    typedef logic [CW-1:0]  count_t;
    typedef logic [CHW-1:0] char_t;

    localparam count_t CAP_COUNT = count_t'(CAPACITY);

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_LEFT   = 3'd1,
        KIND_RIGHT  = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_FLUSH  = 3'd4
    } kind_t;

    // one port's worth of stack memory access
    typedef struct packed {
        logic  we;
        addr_t waddr;
        char_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

endpackage

FILE: hdl/cle_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module cle_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/cle_ctrl.sv
// keystroke sequencer: stack counts, cursor moves and the flush walk
module cle_ctrl
    import cle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic [2:0] kind,
    input  char_t    ch,
    output logic     busy,
    output logic     strobe,
    output char_t    out_char,
    output logic     last,
    output logic     empty_line,
    output logic     overflowed,
    output mem_req_t left_req,
    output mem_req_t right_req,
    input  char_t    left_rdata,
    input  char_t    right_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_L,
        S_MOVE_R,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    count_t lc_reg, lc_next;
    count_t rc_reg, rc_next;
    logic   ovf_reg, ovf_next;
    count_t pos_reg, pos_next;

    // read stage of the flush walk
    logic   pv_reg, pv_next;
    logic   psel_reg, psel_next;
    logic   plast_reg, plast_next;
    logic   pempty_reg, pempty_next;
    logic   povf_reg, povf_next;

    // result registers
    logic   strobe_reg, strobe_next;
    logic   last_reg, last_next;
    logic   empty_reg, empty_next;
    logic   ovfo_reg, ovfo_next;
    char_t  char_reg, char_next;

    count_t total;
    count_t total_m1;
    count_t rev_pos;
    count_t lc_dec;
    count_t rc_dec;

    assign total    = lc_reg + rc_reg;
    assign total_m1 = total - count_t'(1);
    assign rev_pos  = total_m1 - pos_reg;
    assign lc_dec   = lc_reg - count_t'(1);
    assign rc_dec   = rc_reg - count_t'(1);

    always_comb
    begin
        state_next  = state_reg;
        lc_next     = lc_reg;
        rc_next     = rc_reg;
        ovf_next    = ovf_reg;
        pos_next    = pos_reg;
        pv_next     = 1'b0;
        psel_next   = psel_reg;
        plast_next  = plast_reg;
        pempty_next = pempty_reg;
        povf_next   = povf_reg;
        left_req    = '0;
        right_req   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (total >= CAP_COUNT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                left_req.we    = 1'b1;
                                left_req.waddr = lc_reg[AW-1:0];
                                left_req.wdata = ch;
                                lc_next        = lc_reg + count_t'(1);
                            end
                        end
                        KIND_LEFT:
                        begin
                            if (lc_reg != '0 && rc_reg < CAP_COUNT)
                            begin
                                left_req.re    = 1'b1;
                                left_req.raddr = lc_dec[AW-1:0];
                                lc_next        = lc_dec;
                                state_next     = S_MOVE_L;
                            end
                        end
                        KIND_RIGHT:
                        begin
                            if (rc_reg != '0 && lc_reg < CAP_COUNT)
                            begin
                                right_req.re    = 1'b1;
                                right_req.raddr = rc_dec[AW-1:0];
                                rc_next         = rc_dec;
                                state_next      = S_MOVE_R;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (lc_reg != '0)
                            begin
                                lc_next = lc_dec;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            if (total == '0)
                            begin
                                // empty line: single marker result, no reads
                                pv_next     = 1'b1;
                                psel_next   = 1'b0;
                                plast_next  = 1'b1;
                                pempty_next = 1'b1;
                                povf_next   = ovf_reg;
                                ovf_next    = 1'b0;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = S_FLUSH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOVE_L:
            begin
                right_req.we    = 1'b1;
                right_req.waddr = rc_reg[AW-1:0];
                right_req.wdata = left_rdata;
                rc_next         = rc_reg + count_t'(1);
                state_next      = S_IDLE;
            end
            S_MOVE_R:
            begin
                left_req.we    = 1'b1;
                left_req.waddr = lc_reg[AW-1:0];
                left_req.wdata = right_rdata;
                lc_next        = lc_reg + count_t'(1);
                state_next     = S_IDLE;
            end
            S_FLUSH:
            begin
                // left stack bottom-up, then right stack top-down
                if (pos_reg < lc_reg)
                begin
                    left_req.re    = 1'b1;
                    left_req.raddr = pos_reg[AW-1:0];
                    psel_next      = 1'b0;
                end
                else
                begin
                    right_req.re    = 1'b1;
                    right_req.raddr = rev_pos[AW-1:0];
                    psel_next       = 1'b1;
                end
                pv_next     = 1'b1;
                pempty_next = 1'b0;
                povf_next   = ovf_reg;
                plast_next  = (pos_reg == total_m1);
                pos_next    = pos_reg + count_t'(1);
                if (pos_reg == total_m1)
                begin
                    lc_next    = '0;
                    rc_next    = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        strobe_next = pv_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;
        ovfo_next   = ovfo_reg;
        char_next   = char_reg;
        if (pv_reg)
        begin
            last_next  = plast_reg;
            empty_next = pempty_reg;
            ovfo_next  = povf_reg;
            if (pempty_reg)
            begin
                char_next = '0;
            end
            else if (psel_reg)
            begin
                char_next = right_rdata;
            end
            else
            begin
                char_next = left_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lc_reg     <= '0;
            rc_reg     <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            pv_reg     <= 1'b0;
            psel_reg   <= 1'b0;
            plast_reg  <= 1'b0;
            pempty_reg <= 1'b0;
            povf_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            empty_reg  <= 1'b0;
            ovfo_reg   <= 1'b0;
            char_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lc_reg     <= lc_next;
            rc_reg     <= rc_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            pv_reg     <= pv_next;
            psel_reg   <= psel_next;
            plast_reg  <= plast_next;
            pempty_reg <= pempty_next;
            povf_reg   <= povf_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            empty_reg  <= empty_next;
            ovfo_reg   <= ovfo_next;
            char_reg   <= char_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign out_char   = char_reg;
    assign last       = last_reg;
    assign empty_line = empty_reg;
    assign overflowed = ovfo_reg;

endmodule

FILE: hdl/cursor_line_editor.sv
// gap buffer line editor: two stack rams and the keystroke sequencer
// insert, delete and ignored codes leave busy low; a cursor move reads the stack
// top, then writes it to the other stack, with busy high for one cycle.
// a flush keeps busy high while it walks the line, one ram read per cycle;
// results follow one per cycle via the read stage and the result registers.
// an empty-line flush gives one marker result via the same registers, no ram read.
// reset clears counts, overflow flag and control; ram contents are not cleared.
module cursor_line_editor
    import cle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] kind,
    input  logic [7:0] ch,
    output logic       busy,
    output logic       strobe,
    output logic [7:0] out_char,
    output logic       last,
    output logic       empty_line,
    output logic       overflowed
);

    mem_req_t left_req;
    mem_req_t right_req;
    char_t    left_rdata;
    char_t    right_rdata;

    cle_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (CHW)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_req.we),
        .waddr (left_req.waddr),
        .wdata (left_req.wdata),
        .re    (left_req.re),
        .raddr (left_req.raddr),
        .rdata (left_rdata)
    );

    cle_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (CHW)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_req.we),
        .waddr (right_req.waddr),
        .wdata (right_req.wdata),
        .re    (right_req.re),
        .raddr (right_req.raddr),
        .rdata (right_rdata)
    );

    cle_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .ch          (ch),
        .busy        (busy),
        .strobe      (strobe),
        .out_char    (out_char),
        .last        (last),
        .empty_line  (empty_line),
        .overflowed  (overflowed),
        .left_req    (left_req),
        .right_req   (right_req),
        .left_rdata  (left_rdata),
        .right_rdata (right_rdata)
    );

    // an empty-line result stands alone and carries a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && empty_line |-> last && out_char == 8'd0)
    else $error("empty-line result not marked last or character not zero");

    // a flush delivers its characters without gaps up to the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && !empty_line)
    else $error("gap or empty marker inside a flush");

    // the overflow indication cannot change within one flush
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> overflowed == $past(overflowed))
    else $error("overflow indication changed within a flush");

endmodule

FILE: tb/cursor_line_editor_test.sv
// self-checking testbench for the cursor line editor with a gap buffer line predictor
`timescale 1ns / 1ps

module cursor_line_editor_test
    import cle_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [2:0] kind;
    logic [7:0] ch;
    logic       busy;
    logic       strobe;
    logic [7:0] out_char;
    logic       last;
    logic       empty_line;
    logic       overflowed;

    typedef struct {
        char_t c;
        bit    fin;
        bit    blank;
        bit    lost;
    } glyph_t;

    class line_scoreboard;
        char_t  left_text[CAPACITY];
        char_t  right_text[CAPACITY];
        int     left_len;
        int     right_len;
        bit     insert_dropped;
        glyph_t pending[$];
        int     errors;

        function new();
            left_len       = 0;
            right_len      = 0;
            insert_dropped = 0;
            errors         = 0;
        endfunction

        // one accepted keystroke: update the line and queue any flush output
        function void note_key(logic [2:0] k, char_t c);
            glyph_t g;
            int     total;
            int     n;
            case (k)
                KIND_INSERT: begin
                    if (left_len + right_len >= CAPACITY)
                        insert_dropped = 1;
                    else begin
                        left_text[left_len] = c;
                        left_len++;
                    end
                end
                KIND_LEFT: begin
                    if (left_len > 0) begin
                        left_len--;
                        right_text[right_len] = left_text[left_len];
                        right_len++;
                    end
                end
                KIND_RIGHT: begin
                    if (right_len > 0) begin
                        right_len--;
                        left_text[left_len] = right_text[right_len];
                        left_len++;
                    end
                end
                KIND_DELETE: begin
                    if (left_len > 0)
                        left_len--;
                end
                KIND_FLUSH: begin
                    total = left_len + right_len;
                    g.lost = insert_dropped;
                    if (total == 0) begin
                        g.c = '0;
                        g.fin = 1;
                        g.blank = 1;
                        pending = {pending, g};
                    end else begin
                        n = 0;
                        g.blank = 0;
                        for (int i = 0; i < left_len; i++) begin
                            n++;
                            g.c = left_text[i];
                            g.fin = (n == total);
                            pending = {pending, g};
                        end
                        for (int i = right_len; i > 0; i--) begin
                            n++;
                            g.c = right_text[i-1];
                            g.fin = (n == total);
                            pending = {pending, g};
                        end
                    end
                    left_len = 0;
                    right_len = 0;
                    insert_dropped = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_glyph(char_t c, logic l, logic e, logic o);
            glyph_t g;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: char %02h last %b empty %b ovf %b",
                             c, l, e, o);
                return;
            end
            g = pending.pop_front();
            if (c !== g.c || l !== g.fin || e !== g.blank || o !== g.lost) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp char %02h last %b empty %b ovf %b, got %02h %b %b %b",
                             g.c, g.fin, g.blank, g.lost, c, l, e, o);
            end
        endfunction
    endclass

    line_scoreboard sb;
    int             burst_left;
    int             keys_sent;

    cursor_line_editor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .ch         (ch),
        .busy       (busy),
        .strobe     (strobe),
        .out_char   (out_char),
        .last       (last),
        .empty_line (empty_line),
        .overflowed (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("cursor_line_editor test failed");
        $finish;
    end

    // results change at the rising edge, so mid-cycle sampling is race free
    always @(negedge clk)
    begin
        if (rst_n && strobe)
            sb.check_glyph(out_char, last, empty_line, overflowed);
    end

    // one keystroke transfer; called just after a rising edge
    task automatic press(input logic [2:0] k, input char_t c);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                kind  <= 3'($urandom_range(0, 7));
                ch    <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        kind  <= k;
        ch    <= c;
        taken = 0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        sb.note_key(k, c);
        keys_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic fill_line();
        for (int i = 0; i < CAPACITY; i++)
            press(KIND_INSERT, 8'($urandom_range(0, 255)));
        press(KIND_INSERT, 8'hFF);
        press(KIND_INSERT, 8'h00);
    endtask

    // a line of random keystrokes ended by a flush; long lines aim past capacity
    task automatic random_line();
        int  goal;
        int  ins_w;
        int  r;
        goal  = 0;
        ins_w = 55;
        if ($urandom_range(0, 11) == 0) begin
            goal  = $urandom_range(CAPACITY + 2, CAPACITY + 16);
            ins_w = 90;
        end else
            goal = $urandom_range(0, 12);
        for (int i = 0; i < goal; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_w)
                press(KIND_INSERT, 8'($urandom_range(0, 255)));
            else if (r < ins_w + (100 - ins_w) * 3 / 10)
                press(KIND_LEFT, 8'($urandom_range(0, 255)));
            else if (r < ins_w + (100 - ins_w) * 6 / 10)
                press(KIND_RIGHT, 8'($urandom_range(0, 255)));
            else if (r < ins_w + (100 - ins_w) * 85 / 100)
                press(KIND_DELETE, 8'($urandom_range(0, 255)));
            else if (r < 97)
                press(3'(KIND_FLUSH) + 3'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            else
                press(KIND_FLUSH, 8'($urandom_range(0, 255)));
        end
        press(KIND_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        sb         = new();
        burst_left = 0;
        keys_sent  = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = '0;
        ch         = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of an empty line, ignored codes, byte extremes, cursor round trip
        press(KIND_FLUSH, 8'h00);
        press(KIND_LEFT, 8'h00);
        press(KIND_RIGHT, 8'hFF);
        press(KIND_DELETE, 8'h00);
        press(3'(KIND_FLUSH) + 3'd1, 8'h41);
        press(3'(KIND_FLUSH) + 3'd2, 8'h42);
        press(3'(KIND_FLUSH) + 3'd3, 8'hFF);
        press(KIND_INSERT, 8'h00);
        press(KIND_INSERT, 8'hFF);
        press(KIND_INSERT, "<");
        press(KIND_LEFT, 8'h00);
        press(KIND_LEFT, 8'h00);
        press(KIND_LEFT, 8'h00);
        press(KIND_LEFT, 8'h00);
        press(KIND_DELETE, 8'h00);
        press(KIND_RIGHT, 8'h00);
        press(KIND_INSERT, ">");
        press(KIND_DELETE, 8'h00);
        press(KIND_RIGHT, 8'h00);
        press(KIND_RIGHT, 8'h00);
        press(KIND_RIGHT, 8'h00);
        press(KIND_INSERT, "-");
        press(KIND_FLUSH, 8'h00);

        // full buffer: dropped inserts, room made by a delete, then overflow flush
        fill_line();
        press(KIND_LEFT, 8'h00);
        press(KIND_DELETE, 8'h00);
        press(KIND_INSERT, 8'h5A);
        press(KIND_INSERT, 8'hA5);
        press(KIND_FLUSH, 8'h00);
        press(KIND_FLUSH, 8'h00);
        drain();
        @(posedge clk);

        // overflow flag still reported on a line emptied by deletes
        fill_line();
        for (int i = 0; i < CAPACITY + 1; i++)
            press(KIND_DELETE, 8'($urandom_range(0, 255)));
        press(KIND_FLUSH, 8'h00);

        while (keys_sent < 230) begin
            random_line();
            if ($urandom_range(0, 7) == 0) begin
                drain();
                @(posedge clk);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cursor_line_editor test passed");
        else
            $display("cursor_line_editor test failed");
        $finish;
    end

endmodule
